/* src/nqbs_pkg.sv */
package nqbs_pkg;

	localparam int MAX_NESTING = 16;
	localparam int INDEX_BITS  = 16;
	localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
	localparam int ADDR_W      = $clog2(MAX_NESTING);
	localparam int OUT_IDX_W   = 16;
	localparam int EXT_W       = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;
	localparam int STATUS_W    = 3;
	localparam int CTX_W       = 2;

	typedef logic [CTX_W-1:0] ctx_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam ctx_t CTX_NONE = 2'd0;
	localparam ctx_t CTX_SQ   = 2'd1;
	localparam ctx_t CTX_DQ   = 2'd2;
	localparam ctx_t CTX_BR   = 2'd3;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_NOTERM   = 3'd1;
	localparam status_t ST_OVERFLOW = 3'd5;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic                 done;
		logic [OUT_IDX_W-1:0] idx;
		status_t              status;
	} scan_res_t;

	function automatic logic [7:0] closer(input ctx_t ctx);
		logic [7:0] ch;
		case (ctx)
			CTX_SQ:  ch = CH_SQ;
			CTX_DQ:  ch = CH_DQ;
			default: ch = CH_RBRACE;
		endcase
		return ch;
	endfunction

	function automatic ctx_t opens(input ctx_t ctx, input logic [7:0] ch);
		ctx_t nc;
		nc = CTX_NONE;
		if (ch == CH_SQ && ctx != CTX_SQ)
			nc = CTX_SQ;
		else if (ch == CH_DQ && ctx != CTX_DQ)
			nc = CTX_DQ;
		else if (ch == CH_LBRACE)
			nc = CTX_BR;
		return nc;
	endfunction

endpackage

/* src/nqbs_ram.sv */
module nqbs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/nqbs_ctrl.sv */
module nqbs_ctrl
	import nqbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      acc,
	input  logic      first_char,
	input  logic [7:0] character,
	input  logic      scan_mode,
	output scan_res_t res
);

	logic [INDEX_BITS-1:0] pos_q, pos_n;
	logic [DEPTH_W-1:0]    depth_q, depth_n, depth_eff, raddr_full;
	ctx_t                  top_q, top_n, ctx, nc, below;
	logic                  active_q, active_n;
	logic                  we, re, popped;
	logic [ADDR_W-1:0]     waddr, raddr;
	logic [EXT_W-1:0]      pos_ext;

	// below holds the entry under the top of stack, read when depth last changed
	nqbs_ram #(.WIDTH(CTX_W), .DEPTH(MAX_NESTING)) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (top_n),
		.re    (re),
		.raddr (raddr),
		.rdata (below)
	);

	always_comb begin
		depth_eff = first_char ? '0 : depth_q;
		if (first_char)
			pos_n = '0;
		else if (pos_q != '1)
			pos_n = pos_q + INDEX_BITS'(1);
		else
			pos_n = pos_q;
		pos_ext = EXT_W'(pos_n);

		ctx      = (depth_eff != '0) ? top_q : CTX_NONE;
		nc       = opens(ctx, character);
		res.done   = 1'b0;
		res.status = ST_OK;
		res.idx    = (pos_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : pos_ext[OUT_IDX_W-1:0];
		depth_n  = depth_eff;
		top_n    = top_q;
		active_n = first_char | active_q;
		we       = 1'b0;
		popped   = 1'b0;
		waddr    = depth_eff[ADDR_W-1:0];

		if (first_char || active_q) begin
			if (ctx == CTX_NONE) begin
				if (!scan_mode) begin
					if (character == CH_SEMI) begin
						res.done = 1'b1;
					end else if (character == CH_NUL) begin
						res.done   = 1'b1;
						res.status = ST_NOTERM;
						res.idx    = '0;
					end
				end else if (character == CH_SPACE || character == CH_NUL) begin
					res.done = 1'b1;
				end
			end else begin
				if (character == closer(ctx)) begin
					popped  = 1'b1;
					depth_n = depth_eff - DEPTH_W'(1);
					top_n   = below;
				end else if (character == CH_NUL) begin
					res.done   = 1'b1;
					res.status = STATUS_W'(ctx) + STATUS_W'(1);
					res.idx    = '0;
				end
			end
			if (!res.done && !popped && nc != CTX_NONE) begin
				if (depth_eff >= DEPTH_W'(MAX_NESTING)) begin
					res.done   = 1'b1;
					res.status = ST_OVERFLOW;
					res.idx    = '0;
				end else begin
					we      = acc;
					top_n   = nc;
					depth_n = depth_eff + DEPTH_W'(1);
				end
			end
			if (res.done)
				active_n = 1'b0;
		end else begin
			res.idx = '0;
		end

		raddr_full = depth_n - DEPTH_W'(2);
		raddr      = raddr_full[ADDR_W-1:0];
		re         = acc && depth_n >= DEPTH_W'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			depth_q  <= '0;
			top_q    <= CTX_NONE;
			active_q <= 1'b0;
		end else if (acc) begin
			pos_q    <= pos_n;
			depth_q  <= depth_n;
			top_q    <= top_n;
			active_q <= active_n;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_NESTING))
		else $error("stack depth past limit");

	a_restart_active: assert property (@(posedge clk) disable iff (!arst_n)
		acc && first_char && !res.done |=> active_q && depth_q <= DEPTH_W'(1))
		else $error("restart did not start a scan");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.done |-> first_char || active_q)
		else $error("result from idle scanner");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> depth_eff < DEPTH_W'(MAX_NESTING) && depth_n == depth_eff + DEPTH_W'(1))
		else $error("push outside stack");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.done |=> !active_q)
		else $error("scan still active after result");

endmodule

/* src/nested_quote_bracket_scanner_top.sv */
// Scans a script string one byte per beat and reports where the instruction
// (';', scan_mode 0) or argument (space or NUL, scan_mode 1) ends, honoring
// nested single quotes, double quotes and braces up to MAX_NESTING deep.
// Set first_char on byte 0 of each string. One result beat per string gives
// end_index and scan_status; later bytes are dropped until the next
// first_char. Throughput is one byte per clock unless a held result blocks
// in_ready; the context stack lives in a RAM with registered read, and the
// entry under the top of stack is prefetched on every depth change so a pop
// never stalls. No clearing pass after reset. Write scan_mode only while idle.
module nested_quote_bracket_scanner_top
	import nqbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 first_char,
	input  logic [7:0]           character,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_IDX_W-1:0] end_index,
	output logic [STATUS_W-1:0]  scan_status
);

	logic                 scan_mode_q;
	logic                 out_valid_q;
	logic [OUT_IDX_W-1:0] end_index_q;
	status_t              scan_status_q;
	logic                 acc;
	scan_res_t            res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;

	nqbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.first_char (first_char),
		.character  (character),
		.scan_mode  (scan_mode_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				scan_mode_q <= cfg_data;
			if (acc && res.done)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && res.done) begin
			end_index_q   <= res.idx;
			scan_status_q <= res.status;
		end
	end

	assign out_valid   = out_valid_q;
	assign end_index   = end_index_q;
	assign scan_status = scan_status_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import nqbs_pkg::*;

	localparam status_t ST_OPEN_SQ = 3'd2;
	localparam status_t ST_OPEN_DQ = 3'd3;
	localparam status_t ST_OPEN_BR = 3'd4;
	localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
	localparam logic [EXT_W-1:0] OUT_MAX = {OUT_IDX_W{1'b1}};
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {FEED_BYTE, FEED_MODE, FEED_DRAIN, FEED_PACE} feed_kind_t;

	typedef struct {
		feed_kind_t kind;
		logic       first;
		logic [7:0] ch;
		logic       mode;
		int         snd_pct;
		int         rcv_pct;
	} feed_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		status_t              st;
	} scan_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic first_char = 1'b0;
	logic [7:0] character = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OUT_IDX_W-1:0] end_index;
	logic [STATUS_W-1:0] scan_status;

	feed_t char_feed[$];
	scan_end_t pending_ends[$];
	int fed = 0;
	int errors = 0;
	logic all_sent = 1'b0;

	// driver pacing
	int snd_idle = 0;
	int rcv_idle = 0;
	logic settling = 1'b0;
	int settle_cnt = 0;

	// scanner state as predicted
	logic mode_m = 1'b0;
	logic scanning_m = 1'b0;
	logic [INDEX_BITS-1:0] pos_m = '0;
	ctx_t ctx_stack_m [MAX_NESTING];
	int depth_m = 0;
	int stuck_cycles = 0;

	nested_quote_bracket_scanner_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_char  (first_char),
		.character   (character),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.end_index   (end_index),
		.scan_status (scan_status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic put_byte(input logic fc, input logic [7:0] ch);
		feed_t f;
		f = '{kind: FEED_BYTE, first: fc, ch: ch, mode: 1'b0, snd_pct: 0, rcv_pct: 0};
		char_feed.push_back(f);
		fed++;
	endtask

	task automatic put_mode(input logic m);
		feed_t f;
		f = '{kind: FEED_MODE, first: 1'b0, ch: 8'h00, mode: m, snd_pct: 0, rcv_pct: 0};
		char_feed.push_back(f);
	endtask

	task automatic put_drain();
		feed_t f;
		f = '{kind: FEED_DRAIN, first: 1'b0, ch: 8'h00, mode: 1'b0, snd_pct: 0, rcv_pct: 0};
		char_feed.push_back(f);
	endtask

	task automatic put_pace(input int snd, input int rcv);
		feed_t f;
		f = '{kind: FEED_PACE, first: 1'b0, ch: 8'h00, mode: 1'b0, snd_pct: snd, rcv_pct: rcv};
		char_feed.push_back(f);
	endtask

	// mostly nested, balanced strings ending on the terminator of the mode
	task automatic put_script(input logic m, input int open_pct);
		ctx_t gs[$];
		ctx_t top, nc;
		int len, r, i;
		logic [7:0] ch;
		logic fc, stop;
		len = $urandom_range(40, 2);
		fc = 1'b1;
		stop = 1'b0;
		for (i = 0; i < len && !stop; i++) begin
			top = (gs.size() != 0) ? gs[$] : CTX_NONE;
			r = $urandom_range(99);
			if (r < 4) begin
				ch = 8'($urandom_range(255));
			end else if (r < 4 + open_pct) begin
				case ($urandom_range(2))
					0: nc = CTX_SQ;
					1: nc = CTX_DQ;
					default: nc = CTX_BR;
				endcase
				if (nc == top && nc != CTX_BR)
					nc = CTX_BR;
				ch = (nc == CTX_SQ) ? CH_SQ : (nc == CTX_DQ) ? CH_DQ : CH_LBRACE;
				gs.push_back(nc);
			end else if (r < 50 && gs.size() != 0) begin
				ch = (top == CTX_SQ) ? CH_SQ : (top == CTX_DQ) ? CH_DQ : CH_RBRACE;
				void'(gs.pop_back());
			end else if (r < 53) begin
				ch = CH_NUL;
				stop = 1'b1;
			end else if (r < 58) begin
				ch = r[0] ? CH_SPACE : CH_SEMI;
			end else if (r >= 85 && gs.size() == 0) begin
				ch = m ? CH_SPACE : CH_SEMI;
				stop = 1'b1;
			end else begin
				ch = 8'($urandom_range(122, 97));
			end
			put_byte(fc, ch);
			fc = 1'b0;
		end
	endtask

	task automatic end_scan(input logic [EXT_W-1:0] at, input status_t st);
		scan_end_t e;
		e.idx = (at > OUT_MAX) ? OUT_MAX[OUT_IDX_W-1:0] : at[OUT_IDX_W-1:0];
		e.st = st;
		pending_ends.push_back(e);
		scanning_m = 1'b0;
	endtask

	task automatic track_scan(input logic fc, input logic [7:0] ch);
		ctx_t top, nc;
		logic [7:0] shut;
		status_t open_st;
		if (fc) begin
			scanning_m = 1'b1;
			pos_m = '0;
			depth_m = 0;
		end else if (!scanning_m) begin
			return;
		end else if (pos_m != POS_MAX) begin
			pos_m = pos_m + 1'b1;
		end
		top = (depth_m > 0) ? ctx_stack_m[depth_m-1] : CTX_NONE;
		if (top == CTX_NONE) begin
			if (!mode_m) begin
				if (ch == CH_SEMI) begin
					end_scan(pos_m, ST_OK);
					return;
				end
				if (ch == CH_NUL) begin
					end_scan('0, ST_NOTERM);
					return;
				end
			end else if (ch == CH_SPACE || ch == CH_NUL) begin
				end_scan(pos_m, ST_OK);
				return;
			end
		end else begin
			case (top)
				CTX_SQ: begin
					shut = CH_SQ;
					open_st = ST_OPEN_SQ;
				end
				CTX_DQ: begin
					shut = CH_DQ;
					open_st = ST_OPEN_DQ;
				end
				default: begin
					shut = CH_RBRACE;
					open_st = ST_OPEN_BR;
				end
			endcase
			if (ch == shut) begin
				depth_m--;
				return;
			end
			if (ch == CH_NUL) begin
				end_scan('0, open_st);
				return;
			end
		end
		nc = CTX_NONE;
		if (ch == CH_SQ && top != CTX_SQ)
			nc = CTX_SQ;
		else if (ch == CH_DQ && top != CTX_DQ)
			nc = CTX_DQ;
		else if (ch == CH_LBRACE)
			nc = CTX_BR;
		if (nc != CTX_NONE) begin
			if (depth_m >= MAX_NESTING) begin
				end_scan('0, ST_OVERFLOW);
				return;
			end
			ctx_stack_m[depth_m] = nc;
			depth_m++;
		end
	endtask

	task automatic report_miss(input string what, input int want, input int got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : drv
		feed_t f;
		logic nxt_in, nxt_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			out_ready <= 1'b0;
			first_char <= 1'b0;
			character <= 8'h00;
			cfg_data <= 1'b0;
		end else begin
			nxt_in = in_valid && !in_ready;
			nxt_cfg = cfg_valid && !cfg_ready;
			out_ready <= ($urandom_range(99) >= rcv_idle);
			if (!nxt_in && !nxt_cfg) begin
				if (settling) begin
					if (pending_ends.size() != 0) begin
						settle_cnt = 0;
					end else begin
						settle_cnt = settle_cnt + 1;
						if (settle_cnt >= SETTLE_CYCLES)
							settling = 1'b0;
					end
				end else if (char_feed.size() == 0) begin
					all_sent <= 1'b1;
				end else begin
					case (char_feed[0].kind)
						FEED_PACE: begin
							f = char_feed.pop_front();
							snd_idle = f.snd_pct;
							rcv_idle = f.rcv_pct;
						end
						FEED_DRAIN: begin
							void'(char_feed.pop_front());
							settling = 1'b1;
							settle_cnt = 0;
						end
						FEED_MODE: begin
							f = char_feed.pop_front();
							nxt_cfg = 1'b1;
							cfg_data <= f.mode;
						end
						default: begin
							if ($urandom_range(99) >= snd_idle) begin
								f = char_feed.pop_front();
								nxt_in = 1'b1;
								first_char <= f.first;
								character <= f.ch;
							end
						end
					endcase
				end
			end
			in_valid <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk or negedge arst_n) begin : mon
		scan_end_t want;
		if (!arst_n) begin
			mode_m = 1'b0;
			scanning_m = 1'b0;
			pos_m = '0;
			depth_m = 0;
			stuck_cycles = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_m = cfg_data;
			if (in_valid && in_ready)
				track_scan(first_char, character);
			if (out_valid && out_ready) begin
				if (pending_ends.size() == 0) begin
					report_miss("unexpected result beat, end_index", -1, end_index);
				end else begin
					want = pending_ends.pop_front();
					if (end_index !== want.idx)
						report_miss("end_index", want.idx, end_index);
					if (scan_status !== want.st)
						report_miss("scan_status", want.st, scan_status);
				end
			end
			if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stim
		int ph, blk, target, i;
		logic m;

		// directed
		put_pace(0, 0);
		put_byte(1'b0, "a");
		put_byte(1'b1, CH_LBRACE);
		put_byte(1'b0, CH_SQ);
		put_byte(1'b0, CH_DQ);
		put_byte(1'b0, CH_NUL);
		put_byte(1'b1, CH_SQ);
		put_byte(1'b0, CH_NUL);
		put_byte(1'b1, CH_LBRACE);
		put_byte(1'b0, CH_RBRACE);
		put_byte(1'b0, CH_SEMI);
		put_byte(1'b1, CH_NUL);
		put_byte(1'b1, CH_LBRACE);
		put_byte(1'b1, CH_LBRACE);
		put_byte(1'b0, CH_NUL);
		put_byte(1'b1, 8'hFF);
		put_byte(1'b0, CH_SEMI);
		put_byte(1'b1, CH_LBRACE);
		for (i = 0; i < MAX_NESTING - 1; i++)
			put_byte(1'b0, i[0] ? CH_DQ : CH_SQ);
		put_byte(1'b0, CH_LBRACE);
		put_drain();
		put_mode(1'b1);
		put_byte(1'b1, "a");
		put_byte(1'b0, CH_SPACE);
		put_byte(1'b1, CH_LBRACE);
		put_byte(1'b0, CH_SPACE);
		put_byte(1'b0, CH_RBRACE);
		put_byte(1'b0, CH_NUL);
		put_byte(1'b1, "x");
		put_drain();
		put_mode(1'b0);
		put_byte(1'b0, CH_SPACE);
		put_byte(1'b0, CH_SEMI);

		// random
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: put_pace(33, 87);
				1: put_pace(87, 33);
				default: put_pace(0, 0);
			endcase
			for (blk = 0; blk < 4; blk++) begin
				m = (blk < 2) ? blk[0] : 1'($urandom_range(1));
				put_drain();
				put_mode(m);
				target = fed + 150;
				while (fed < target)
					put_script(m, ($urandom_range(9) == 0) ? 40 : 12);
			end
		end
		put_drain();

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (!all_sent)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_ends.size() != 0)
			report_miss("result beats never seen", 0, pending_ends.size());
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* nested_quote_bracket_scanner_top.f */
src/nqbs_pkg.sv
src/nqbs_ram.sv
src/nqbs_ctrl.sv
src/nested_quote_bracket_scanner_top.sv
verif/tb.sv
